// File: sv/mck_pkg.sv
// Shared types and constants for the Morse character keyer.
// Holds the microcode word layout, the letter table and the ASCII codes.
// No dependencies.
package mck_pkg;

  // ASCII anchors for the letter range and the word gap
  localparam logic [7:0] CHAR_FIRST   = 8'd65;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam int         LETTER_COUNT = 26;
  localparam logic [3:0] ON_LEVEL_RST = 4'd15;

  // Microcode program counter
  typedef logic [2:0] upc_t;

  // Branch conditions, tested when a step ends
  typedef enum logic [2:0] {
    COND_NEVER      = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_SPACE      = 3'd2,
    COND_NOT_LETTER = 3'd3,
    COND_MORE_ELEM  = 3'd4,
    COND_NO_EOP     = 3'd5
  } cond_t;

  // Repeat count of an emitting step
  typedef enum logic [1:0] {
    CNT_ELEM  = 2'd0,   // one for a dot, three for a dash
    CNT_THREE = 2'd1,
    CNT_FOUR  = 2'd2,
    CNT_SEVEN = 2'd3
  } cnt_t;

  // When the final unit of a step closes the word
  typedef enum logic [1:0] {
    LAST_NEVER      = 2'd0,
    LAST_ALWAYS     = 2'd1,
    LAST_NO_EOP     = 2'd2,
    LAST_FINAL_ELEM = 2'd3
  } last_t;

  // One control word
  typedef struct packed {
    logic  emit;      // step drives one unit per cycle while the output slot can take it
    logic  lamp_on;   // unit is lit at the configured level
    cnt_t  cnt;
    last_t last;
    logic  adv_elem;  // move to the next element at step end
    cond_t cond;
    upc_t  target;    // branch target; zero ends the word
  } uword_t;

  // Microcode addresses
  localparam upc_t UPC_END   = 3'd0;
  localparam upc_t UPC_DISP  = 3'd0;
  localparam upc_t UPC_CLASS = 3'd1;
  localparam upc_t UPC_MARK  = 3'd2;
  localparam upc_t UPC_EGAP  = 3'd3;
  localparam upc_t UPC_PCHK  = 3'd4;
  localparam upc_t UPC_PGAP  = 3'd5;
  localparam upc_t UPC_SPACE = 3'd6;

  // Letter shape: element count and dash flags, element 0 in bit 0
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dash;
  } letter_t;

  localparam letter_t LETTER_TAB [LETTER_COUNT] = '{
    '{3'd2, 4'b0010}, '{3'd4, 4'b0001}, '{3'd4, 4'b0101}, '{3'd3, 4'b0001},
    '{3'd1, 4'b0000}, '{3'd4, 4'b0100}, '{3'd3, 4'b0011}, '{3'd4, 4'b0000},
    '{3'd2, 4'b0000}, '{3'd4, 4'b1110}, '{3'd3, 4'b0101}, '{3'd4, 4'b0010},
    '{3'd2, 4'b0011}, '{3'd2, 4'b0001}, '{3'd3, 4'b0111}, '{3'd4, 4'b0110},
    '{3'd4, 4'b1011}, '{3'd3, 4'b0010}, '{3'd3, 4'b0000}, '{3'd1, 4'b0001},
    '{3'd3, 4'b0100}, '{3'd4, 4'b1000}, '{3'd3, 4'b0110}, '{3'd4, 4'b1001},
    '{3'd4, 4'b1101}, '{3'd4, 4'b0011}
  };

  // Sequencer to datapath controls
  typedef struct packed {
    logic  load;       // capture a new word
    logic  emit_fire;  // drive one unit this cycle
    logic  step_end;   // current step finishes
    logic  lamp_on;
    cnt_t  cnt;
    last_t last;
    logic  adv_elem;
  } dp_ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic is_space;
    logic not_letter;
    logic more_elem;
    logic no_eop;
    logic rep_last;
    logic emit_ok;
  } dp_stat_t;

endpackage

// File: sv/mck_ucode_rom.sv
// Microcode store for the Morse character keyer.
// Decodes a program counter into one control word; uses mck_pkg.
module mck_ucode_rom (
  input  mck_pkg::upc_t   upc,
  output mck_pkg::uword_t uword
);

  // Decode the program
  always_comb begin
    unique case (upc)
      // classify: space goes to the four-unit gap
      mck_pkg::UPC_DISP: begin
        uword = '{1'b0, 1'b0, mck_pkg::CNT_THREE, mck_pkg::LAST_NEVER, 1'b0,
                  mck_pkg::COND_SPACE, mck_pkg::UPC_SPACE};
      end
      // anything but a letter skips to the phrase check
      mck_pkg::UPC_CLASS: begin
        uword = '{1'b0, 1'b0, mck_pkg::CNT_THREE, mck_pkg::LAST_NEVER, 1'b0,
                  mck_pkg::COND_NOT_LETTER, mck_pkg::UPC_PCHK};
      end
      // dot or dash
      mck_pkg::UPC_MARK: begin
        uword = '{1'b1, 1'b1, mck_pkg::CNT_ELEM, mck_pkg::LAST_NEVER, 1'b0,
                  mck_pkg::COND_NEVER, mck_pkg::UPC_END};
      end
      // element gap, loop while elements remain
      mck_pkg::UPC_EGAP: begin
        uword = '{1'b1, 1'b0, mck_pkg::CNT_THREE, mck_pkg::LAST_FINAL_ELEM, 1'b1,
                  mck_pkg::COND_MORE_ELEM, mck_pkg::UPC_MARK};
      end
      // finish unless the phrase gap follows
      mck_pkg::UPC_PCHK: begin
        uword = '{1'b0, 1'b0, mck_pkg::CNT_THREE, mck_pkg::LAST_NEVER, 1'b0,
                  mck_pkg::COND_NO_EOP, mck_pkg::UPC_END};
      end
      // phrase gap
      mck_pkg::UPC_PGAP: begin
        uword = '{1'b1, 1'b0, mck_pkg::CNT_SEVEN, mck_pkg::LAST_ALWAYS, 1'b0,
                  mck_pkg::COND_ALWAYS, mck_pkg::UPC_END};
      end
      // word gap for a space
      mck_pkg::UPC_SPACE: begin
        uword = '{1'b1, 1'b0, mck_pkg::CNT_FOUR, mck_pkg::LAST_NO_EOP, 1'b0,
                  mck_pkg::COND_ALWAYS, mck_pkg::UPC_PCHK};
      end
      default: begin
        uword = '{1'b0, 1'b0, mck_pkg::CNT_THREE, mck_pkg::LAST_NEVER, 1'b0,
                  mck_pkg::COND_ALWAYS, mck_pkg::UPC_END};
      end
    endcase
  end

endmodule

// File: sv/mck_sequencer.sv
// Step counter and branch logic for the Morse character keyer.
// Fetches from mck_ucode_rom and drives the datapath; uses mck_pkg.
module mck_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mck_pkg::dp_stat_t  stat,
  output mck_pkg::dp_ctrl_t  ctrl
);

  logic            busy_r, busy_nxt;
  mck_pkg::upc_t   upc_r, upc_nxt;
  mck_pkg::uword_t uword;
  logic            fire;
  logic            step_end;
  logic            taken;
  logic            accept;

  mck_ucode_rom u_rom (
    .upc   (upc_r),
    .uword (uword)
  );

  // Advance when idle-free, emitting steps wait for the output slot
  assign accept   = in_valid && !busy_r;
  assign fire     = busy_r && (!uword.emit || stat.emit_ok);
  assign step_end = fire && (!uword.emit || stat.rep_last);
  assign in_stall = busy_r;

  // Evaluate the branch condition
  always_comb begin
    unique case (uword.cond)
      mck_pkg::COND_NEVER:      taken = 1'b0;
      mck_pkg::COND_ALWAYS:     taken = 1'b1;
      mck_pkg::COND_SPACE:      taken = stat.is_space;
      mck_pkg::COND_NOT_LETTER: taken = stat.not_letter;
      mck_pkg::COND_MORE_ELEM:  taken = stat.more_elem;
      mck_pkg::COND_NO_EOP:     taken = stat.no_eop;
      default:                  taken = 1'b1;
    endcase
  end

  // Next step; a taken branch to the end address drops busy
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      upc_nxt  = mck_pkg::UPC_DISP;
    end else if (step_end) begin
      if (taken) begin
        upc_nxt = uword.target;
        if (uword.target == mck_pkg::UPC_END) begin
          busy_nxt = 1'b0;
        end
      end else begin
        upc_nxt = upc_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= mck_pkg::UPC_END;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  // Controls to the datapath
  always_comb begin
    ctrl.load      = accept;
    ctrl.emit_fire = fire && uword.emit;
    ctrl.step_end  = step_end;
    ctrl.lamp_on   = uword.lamp_on;
    ctrl.cnt       = uword.cnt;
    ctrl.last      = uword.last;
    ctrl.adv_elem  = uword.adv_elem;
  end

  // Idle always parks on the end address
  a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> upc_r == mck_pkg::UPC_END)
    else $error("sequencer idle away from end address");

  // No word is taken while one is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctrl.load)
    else $error("word loaded while busy");

endmodule

// File: sv/mck_datapath.sv
// Datapath for the Morse character keyer: word capture, element and unit
// counters, level register and output stage. Uses mck_pkg.
module mck_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_char_code,
  input  logic              in_end_of_phrase,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  mck_pkg::dp_ctrl_t ctrl,
  output mck_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_lamp_level,
  output logic              out_last_unit
);

  logic [3:0] on_level_r;
  logic       eop_r, is_space_r, is_letter_r;
  logic [2:0] len_r;
  logic [3:0] dash_r;
  logic [1:0] elem_r, elem_nxt;
  logic [2:0] rep_r, rep_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] lamp_r;
  logic       last_r;
  logic [7:0] ofs;
  logic       in_letter;
  mck_pkg::letter_t shape;
  logic [2:0] rep_max;
  logic       more_elem;
  logic       unit_last;

  // Classify the incoming character
  assign ofs       = in_char_code - mck_pkg::CHAR_FIRST;
  assign in_letter = ofs < 8'(mck_pkg::LETTER_COUNT);
  assign shape     = mck_pkg::LETTER_TAB[ofs[4:0]];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_level_r <= mck_pkg::ON_LEVEL_RST;
    end else if (cfg_wr_en) begin
      on_level_r <= cfg_wr_data;
    end
  end

  // Hold the word being keyed
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      eop_r       <= in_end_of_phrase;
      is_space_r  <= in_char_code == mck_pkg::CHAR_SPACE;
      is_letter_r <= in_letter;
      len_r       <= shape.len;
      dash_r      <= shape.dash;
    end
  end

  // Repeat count of the current step
  always_comb begin
    case (ctrl.cnt)
      mck_pkg::CNT_ELEM:  rep_max = dash_r[elem_r] ? 3'd2 : 3'd0;
      mck_pkg::CNT_THREE: rep_max = 3'd2;
      mck_pkg::CNT_FOUR:  rep_max = 3'd3;
      default:            rep_max = 3'd6;
    endcase
  end

  assign more_elem = ({1'b0, elem_r} + 3'd1) < len_r;

  // Final-unit rule of the current step
  always_comb begin
    case (ctrl.last)
      mck_pkg::LAST_ALWAYS:     unit_last = 1'b1;
      mck_pkg::LAST_NO_EOP:     unit_last = !eop_r;
      mck_pkg::LAST_FINAL_ELEM: unit_last = !more_elem && !eop_r;
      default:                  unit_last = 1'b0;
    endcase
  end

  // Advance the unit and element counters
  always_comb begin
    rep_nxt  = rep_r;
    elem_nxt = elem_r;
    if (ctrl.load) begin
      rep_nxt  = 3'd0;
      elem_nxt = 2'd0;
    end else begin
      if (ctrl.emit_fire) begin
        rep_nxt = rep_r + 3'd1;
      end
      if (ctrl.step_end) begin
        rep_nxt = 3'd0;
        if (ctrl.adv_elem) begin
          elem_nxt = elem_r + 2'd1;
        end
      end
    end
  end

  // Output stage: load a unit or drop the taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r       <= 3'd0;
      elem_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      rep_r       <= rep_nxt;
      elem_r      <= elem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_fire) begin
      lamp_r <= ctrl.lamp_on ? on_level_r : 4'd0;
      last_r <= (rep_r == rep_max) && unit_last;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat.is_space   = is_space_r;
    stat.not_letter = !is_letter_r;
    stat.more_elem  = more_elem;
    stat.no_eop     = !eop_r;
    stat.rep_last   = rep_r == rep_max;
    stat.emit_ok    = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_lamp_level = lamp_r;
  assign out_last_unit  = last_r;

  // A unit is only driven into a free or draining output slot
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit_fire |-> (!out_valid_r || !out_stall))
    else $error("unit driven over a stalled word");

  // The final unit of a word is always a gap unit
  a_last_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> lamp_r == 4'd0)
    else $error("final unit is lit");

  // No step runs past seven units
  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r != 3'd7)
    else $error("unit counter overran");

endmodule

// File: sv/morse_character_keyer_top.sv
// Top level of the Morse character keyer.
// Instantiates mck_sequencer and mck_datapath; uses mck_pkg.
//
// Each accepted word carries one ASCII character and a phrase-end flag and
// expands into a run of lamp units, one output word per unit: A to Z in
// international Morse (dot one lit unit, dash three, each element followed
// by three dark units), a space gives four dark units, any other code gives
// none, and the phrase-end flag appends seven dark units. The final unit of
// a run carries out_last_unit. A word occupies the block for its units plus
// its non-emitting microcode control steps, and in_stall stays high until
// the word is done, so the next character is taken only after the last
// one has finished; the rate is set by the microcode sequencer, which steps
// one unit per cycle and holds an emitting step while the output stage is
// stalled with a unit in it. cfg_wr_data sets the lit level.
module morse_character_keyer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_phrase,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_lamp_level,
  output logic       out_last_unit,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  mck_pkg::dp_ctrl_t ctrl;
  mck_pkg::dp_stat_t stat;

  mck_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mck_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_code     (in_char_code),
    .in_end_of_phrase (in_end_of_phrase),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lamp_level   (out_lamp_level),
    .out_last_unit    (out_last_unit)
  );

endmodule
